// ===== design/min_weight_bridge_finder_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the lightest-bridge finder
// Unless ASSERT_OFF is defined, each macro expands to a concurrent assertion on clk, gated by rst_n.
// ----------------------------------------------------------------------------
`ifndef MIN_WEIGHT_BRIDGE_FINDER_DEFINES_SVH
`define MIN_WEIGHT_BRIDGE_FINDER_DEFINES_SVH

`ifndef ASSERT_OFF
`define MWBF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
`define MWBF_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define MWBF_ASSERT_IMPL(lbl, ante, cons)
`define MWBF_ASSERT_NEVER(lbl, cond)
`endif

`endif

// ===== design/mwbf_pkg.sv =====
// ----------------------------------------------------------------------------
// mwbf_pkg
// Shared constants and types of the lightest-bridge finder.
// ----------------------------------------------------------------------------
package mwbf_pkg;

  localparam int NODE_BITS   = 10;
  localparam int IN_WBITS    = 16;
  localparam int ANS_BITS    = 17;

  localparam logic [1:0] STATUS_BRIDGE  = 2'd0;
  localparam logic [1:0] STATUS_NONE    = 2'd1;
  localparam logic [1:0] STATUS_DISCONN = 2'd2;

  localparam logic                 REG_IDX_NODE_COUNT = 1'b0;
  localparam logic [NODE_BITS-1:0] NODE_COUNT_RESET   = 10'd1;

  typedef struct packed {
    logic                disconnected;
    logic                found;
    logic [IN_WBITS-1:0] weight;
  } res_t;

endpackage

// ===== design/mwbf_result_reg.sv =====
// ----------------------------------------------------------------------------
// mwbf_result_reg
// Formats the search summary into status and answer and holds it until
// the receiver takes the transaction.
// ----------------------------------------------------------------------------
module mwbf_result_reg (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 load,
  input  mwbf_pkg::res_t                       res,
  output logic                                 free,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           out_status,
  output logic [mwbf_pkg::IN_WBITS-1:0]        out_min_bridge_weight,
  output logic signed [mwbf_pkg::ANS_BITS-1:0] out_answer
);

  logic                                 valid_r;
  logic [1:0]                           status_r;
  logic [mwbf_pkg::IN_WBITS-1:0]        minw_r;
  logic signed [mwbf_pkg::ANS_BITS-1:0] ans_r;

  assign free                  = !valid_r || out_ready;
  assign out_valid             = valid_r;
  assign out_status            = status_r;
  assign out_min_bridge_weight = minw_r;
  assign out_answer            = ans_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (res.disconnected) begin
        status_r <= mwbf_pkg::STATUS_DISCONN;
        minw_r   <= '0;
        ans_r    <= '0;
      end else if (!res.found) begin
        status_r <= mwbf_pkg::STATUS_NONE;
        minw_r   <= '0;
        ans_r    <= '1;
      end else begin
        status_r <= mwbf_pkg::STATUS_BRIDGE;
        minw_r   <= res.weight;
        ans_r    <= (res.weight == '0) ? mwbf_pkg::ANS_BITS'(1)
                                       : {1'b0, res.weight};
      end
    end
  end

endmodule

// ===== design/min_weight_bridge_finder.sv =====
// ----------------------------------------------------------------------------
// min_weight_bridge_finder
// Loads an undirected multigraph one edge per transaction into adjacency
// memory; the transaction marked last runs a stack-based bridge search.
//
// Input channel (in_*): valid/ready. A stored edge passes LD_A, LD_A2, LD_B
// and LD_B2 (two head reads and two adjacency writes), with in_ready low;
// an empty marker or a dropped edge is taken in ST_IDLE alone.
// On last_edge the search runs (one read port on each memory): SCAN and
// SCAN_CHK per node scanned; STEP and EDGE per adjacency entry, EDGE2 too if
// not the parent edge; PUSH, PUSH2 per push; POP, then POP2/POP3 as needed.
// One result transaction then leaves on out_*.
// After each graph, and after reset, a clearing pass over all MAX_NODES+1
// entries zeroes list heads and visit times; in_ready is low meanwhile.
// Config port (APB): node_count at address 0; write it only while idle, a
// rule left to the user. Output: held in a register until out_ready; edge
// loading continues while it waits, but a new search does not finish until
// it is taken. Reset is synchronous on rst_n; node_count returns to 1.
// ----------------------------------------------------------------------------
`include "min_weight_bridge_finder_defines.svh"

module min_weight_bridge_finder #(
  parameter int MAX_NODES   = 1023,
  parameter int MAX_EDGES   = 4096,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_carries_edge,
  input  logic [mwbf_pkg::NODE_BITS-1:0]       in_end_a,
  input  logic [mwbf_pkg::NODE_BITS-1:0]       in_end_b,
  input  logic [mwbf_pkg::IN_WBITS-1:0]        in_weight,
  input  logic                                 in_last_edge,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           out_status,
  output logic [mwbf_pkg::IN_WBITS-1:0]        out_min_bridge_weight,
  output logic signed [mwbf_pkg::ANS_BITS-1:0] out_answer
);

  localparam int NW  = $clog2(MAX_NODES + 1);
  localparam int NCW = $clog2(MAX_NODES + 2);
  localparam int EW  = $clog2(MAX_EDGES + 1);
  localparam int EIW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int AIW = $clog2(2 * MAX_EDGES);
  localparam int AW  = $clog2(2 * MAX_EDGES + 1);
  localparam int ND  = MAX_NODES + 1;
  localparam int AD  = 2 * MAX_EDGES;

  typedef struct packed {
    logic [NW-1:0] nb;
    logic [EW-1:0] id;
    logic [AW-1:0] nxt;
  } adj_t;

  typedef struct packed {
    logic [NW-1:0] node;
    logic [EW-1:0] from;
    logic [AW-1:0] ptr;
    logic [NW-1:0] low;
    logic [NW-1:0] tin;
  } stk_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_LD_A, ST_LD_A2, ST_LD_B, ST_LD_B2,
    ST_SCAN, ST_SCAN_CHK, ST_PUSH, ST_PUSH2, ST_STEP, ST_EDGE, ST_EDGE2,
    ST_POP, ST_POP2, ST_POP3, ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic [mwbf_pkg::NODE_BITS-1:0] node_count_r;
  logic [NCW-1:0] n_lim;
  logic [NW-1:0]  a_r, a_nxt, b_r, b_nxt, v_r, v_nxt, u_r, u_nxt;
  logic [NW-1:0]  time_r, time_nxt, low_r, low_nxt, tin_r, tin_nxt;
  logic [NW-1:0]  clow_r, clow_nxt, clr_r, clr_nxt;
  logic           last_r, last_nxt, best_ok_r, best_ok_nxt;
  logic [EW-1:0]  ec_r, ec_nxt, vfrom_r, vfrom_nxt, from_r, from_nxt;
  logic [EW-1:0]  cfrom_r, cfrom_nxt;
  logic [1:0]     comp_r, comp_nxt;
  logic [WEIGHT_BITS-1:0] best_r, best_nxt;
  logic [NCW-1:0] i_r, i_nxt, sp_r, sp_nxt;
  logic [AW-1:0]  ptr_r, ptr_nxt;
  logic           store_ok;
  logic [AIW-1:0] kk;

  adj_t adj_mem [AD];
  logic adj_we;
  logic [AIW-1:0] adj_wa, adj_ra;
  adj_t adj_wd, adj_rd_r;

  logic [AW-1:0] head_mem [ND];
  logic head_we;
  logic [NW-1:0] head_wa, head_ra;
  logic [AW-1:0] head_wd, head_rd_r;

  logic [NW-1:0] vis_mem [ND];
  logic vis_we;
  logic [NW-1:0] vis_wa, vis_ra, vis_wd, vis_rd_r;

  stk_t stk_mem [ND];
  logic stk_we;
  logic [NW-1:0] stk_wa, stk_ra;
  stk_t stk_wd, stk_rd_r;

  logic [WEIGHT_BITS-1:0] wt_mem [MAX_EDGES];
  logic wt_we;
  logic [EIW-1:0] wt_wa, wt_ra;
  logic [WEIGHT_BITS-1:0] wt_wd, wt_rd_r;

  logic           res_load, res_free;
  mwbf_pkg::res_t res;

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr[2] == mwbf_pkg::REG_IDX_NODE_COUNT) ? 32'(node_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= mwbf_pkg::NODE_COUNT_RESET;
    end else if (psel && penable && pwrite && paddr[2] == mwbf_pkg::REG_IDX_NODE_COUNT) begin
      node_count_r <= pwdata[mwbf_pkg::NODE_BITS-1:0];
    end
  end

  assign n_lim = (32'(node_count_r) > MAX_NODES) ? NCW'(MAX_NODES) : NCW'(node_count_r);

  assign store_ok = in_carries_edge && in_end_a != '0 && in_end_b != '0 &&
                    32'(in_end_a) <= 32'(n_lim) && 32'(in_end_b) <= 32'(n_lim) &&
                    32'(ec_r) < MAX_EDGES;
  assign kk       = AIW'({ec_r, 1'b0});
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    a_nxt = a_r; b_nxt = b_r; v_nxt = v_r; u_nxt = u_r;
    time_nxt = time_r; low_nxt = low_r; tin_nxt = tin_r;
    clow_nxt = clow_r; clr_nxt = clr_r; last_nxt = last_r;
    best_ok_nxt = best_ok_r; best_nxt = best_r;
    ec_nxt = ec_r; vfrom_nxt = vfrom_r; from_nxt = from_r; cfrom_nxt = cfrom_r;
    comp_nxt = comp_r; i_nxt = i_r; sp_nxt = sp_r; ptr_nxt = ptr_r;
    adj_we = 1'b0; adj_wa = '0; adj_wd = '0; adj_ra = '0;
    head_we = 1'b0; head_wa = '0; head_wd = '0; head_ra = '0;
    vis_we = 1'b0; vis_wa = '0; vis_wd = '0; vis_ra = '0;
    stk_we = 1'b0; stk_wa = '0; stk_wd = '0; stk_ra = '0;
    wt_we = 1'b0; wt_wa = '0; wt_wd = '0; wt_ra = '0;
    res_load = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        head_we = 1'b1; head_wa = clr_r;
        vis_we = 1'b1;  vis_wa = clr_r;
        ec_nxt = '0; time_nxt = '0; comp_nxt = '0; best_ok_nxt = 1'b0;
        sp_nxt = '0;
        if (clr_r == NW'(MAX_NODES)) begin
          clr_nxt = '0;
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          a_nxt = NW'(in_end_a);
          b_nxt = NW'(in_end_b);
          last_nxt = in_last_edge;
          i_nxt = NCW'(1);
          if (store_ok) begin
            wt_we = 1'b1; wt_wa = EIW'(ec_r); wt_wd = WEIGHT_BITS'(in_weight);
            state_nxt = ST_LD_A;
          end else if (in_last_edge) begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_LD_A: begin
        head_ra = a_r;
        state_nxt = ST_LD_A2;
      end
      ST_LD_A2: begin
        adj_we = 1'b1; adj_wa = kk;
        adj_wd.nb = b_r; adj_wd.id = ec_r + 1'b1; adj_wd.nxt = head_rd_r;
        head_we = 1'b1; head_wa = a_r; head_wd = AW'({ec_r, 1'b0}) + AW'(1);
        state_nxt = ST_LD_B;
      end
      ST_LD_B: begin
        head_ra = b_r;
        state_nxt = ST_LD_B2;
      end
      ST_LD_B2: begin
        adj_we = 1'b1; adj_wa = kk + AIW'(1);
        adj_wd.nb = a_r; adj_wd.id = ec_r + 1'b1; adj_wd.nxt = head_rd_r;
        head_we = 1'b1; head_wa = b_r; head_wd = AW'({ec_r, 1'b0}) + AW'(2);
        ec_nxt = ec_r + 1'b1;
        state_nxt = last_r ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        if (i_r > n_lim) begin
          state_nxt = ST_FINISH;
        end else begin
          vis_ra = NW'(i_r);
          state_nxt = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        if (vis_rd_r == '0) begin
          comp_nxt = (comp_r == 2'd2) ? comp_r : comp_r + 1'b1;
          v_nxt = NW'(i_r);
          vfrom_nxt = '0;
          state_nxt = ST_PUSH;
        end else begin
          i_nxt = i_r + 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_PUSH: begin
        time_nxt = time_r + 1'b1;
        vis_we = 1'b1; vis_wa = v_r; vis_wd = time_r + 1'b1;
        if (sp_r != '0) begin
          stk_we = 1'b1; stk_wa = NW'(sp_r - 1'b1);
          stk_wd.node = u_r; stk_wd.from = from_r; stk_wd.ptr = ptr_r;
          stk_wd.low = low_r; stk_wd.tin = tin_r;
        end
        head_ra = v_r;
        u_nxt = v_r; from_nxt = vfrom_r;
        tin_nxt = time_r + 1'b1; low_nxt = time_r + 1'b1;
        sp_nxt = sp_r + 1'b1;
        state_nxt = ST_PUSH2;
      end
      ST_PUSH2: begin
        ptr_nxt = head_rd_r;
        state_nxt = ST_STEP;
      end
      ST_STEP: begin
        if (ptr_r != '0) begin
          adj_ra = AIW'(ptr_r - 1'b1);
          state_nxt = ST_EDGE;
        end else begin
          state_nxt = ST_POP;
        end
      end
      ST_EDGE: begin
        ptr_nxt = adj_rd_r.nxt;
        if (adj_rd_r.id == from_r) begin
          state_nxt = ST_STEP;
        end else begin
          v_nxt = adj_rd_r.nb; vfrom_nxt = adj_rd_r.id;
          vis_ra = adj_rd_r.nb;
          state_nxt = ST_EDGE2;
        end
      end
      ST_EDGE2: begin
        state_nxt = ST_STEP;
        if (vis_rd_r == '0) begin
          if (32'(sp_r) <= MAX_NODES) state_nxt = ST_PUSH;
        end else if (vis_rd_r < low_r) begin
          low_nxt = vis_rd_r;
        end
      end
      ST_POP: begin
        sp_nxt = sp_r - 1'b1;
        if (sp_r == NCW'(1)) begin
          i_nxt = i_r + 1'b1;
          state_nxt = ST_SCAN;
        end else begin
          clow_nxt = low_r; cfrom_nxt = from_r;
          stk_ra = NW'(sp_r - NCW'(2));
          state_nxt = ST_POP2;
        end
      end
      ST_POP2: begin
        u_nxt = stk_rd_r.node; from_nxt = stk_rd_r.from;
        ptr_nxt = stk_rd_r.ptr; tin_nxt = stk_rd_r.tin;
        low_nxt = (clow_r < stk_rd_r.low) ? clow_r : stk_rd_r.low;
        if (clow_r > stk_rd_r.tin) begin
          wt_ra = EIW'(cfrom_r - 1'b1);
          state_nxt = ST_POP3;
        end else begin
          state_nxt = ST_STEP;
        end
      end
      ST_POP3: begin
        if (!best_ok_r || wt_rd_r < best_r) begin
          best_nxt = wt_rd_r;
          best_ok_nxt = 1'b1;
        end
        state_nxt = ST_STEP;
      end
      ST_FINISH: begin
        if (res_free) begin
          res_load = 1'b1;
          state_nxt = ST_CLEAR;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r <= '0; ec_r <= '0; time_r <= '0; comp_r <= '0;
      best_ok_r <= 1'b0; sp_r <= '0; i_r <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt; ec_r <= ec_nxt; time_r <= time_nxt; comp_r <= comp_nxt;
      best_ok_r <= best_ok_nxt; sp_r <= sp_nxt; i_r <= i_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt; b_r <= b_nxt; v_r <= v_nxt; u_r <= u_nxt;
    low_r <= low_nxt; tin_r <= tin_nxt; clow_r <= clow_nxt;
    last_r <= last_nxt; best_r <= best_nxt;
    vfrom_r <= vfrom_nxt; from_r <= from_nxt; cfrom_r <= cfrom_nxt;
    ptr_r <= ptr_nxt;
  end

  always_ff @(posedge clk) begin
    if (adj_we) adj_mem[adj_wa] <= adj_wd;
    adj_rd_r <= adj_mem[adj_ra];
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd_r <= head_mem[head_ra];
  end

  always_ff @(posedge clk) begin
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    vis_rd_r <= vis_mem[vis_ra];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    stk_rd_r <= stk_mem[stk_ra];
  end

  always_ff @(posedge clk) begin
    if (wt_we) wt_mem[wt_wa] <= wt_wd;
    wt_rd_r <= wt_mem[wt_ra];
  end

  assign res.disconnected = (comp_r > 2'd1);
  assign res.found        = best_ok_r;
  assign res.weight       = mwbf_pkg::IN_WBITS'(best_r);

  mwbf_result_reg u_result (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .load                  (res_load),
    .res                   (res),
    .free                  (res_free),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_status            (out_status),
    .out_min_bridge_weight (out_min_bridge_weight),
    .out_answer            (out_answer)
  );

  `MWBF_ASSERT_IMPL(a_idle_stack_empty, in_ready, sp_r == '0)
  `MWBF_ASSERT_NEVER(a_time_bound, NCW'(time_r) > n_lim)
  `MWBF_ASSERT_NEVER(a_stack_le_time, sp_r > NCW'(time_r))

endmodule
